FILE: rtl/core/poc_pkg.sv
// shared types, constants and a helper function for the order crossover block
`default_nettype none

package poc_pkg;

  // sizes
  localparam int MAX_GENES  = 64;
  localparam int ADDR_W     = $clog2(MAX_GENES);
  localparam int CNT_W      = $clog2(MAX_GENES + 1);
  localparam int GENE_W     = 6;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  typedef logic [GENE_W-1:0] gene_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam cnt_t LEN_RESET = cnt_t'(32);
  localparam cnt_t LEN_MIN   = cnt_t'(2);
  localparam cnt_t LEN_MAX   = cnt_t'(MAX_GENES);

  // crossover modes
  typedef enum logic [1:0] {
    MODE_SEGMENT = 2'd0,
    MODE_HEAD    = 2'd1,
    MODE_TAIL    = 2'd2,
    MODE_MASK    = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 1'b0,
    REG_LEN  = 1'b1
  } cfg_reg_t;

  // back end states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MARK,
    BK_WAIT,
    BK_CHECK
  } bk_state_t;

  // one child build request from the front end
  typedef struct packed {
    cnt_t  len;
    mode_t mode;
    cnt_t  lo;
    cnt_t  hi;
  } job_t;

  // one result word
  typedef struct packed {
    gene_t gene;
    logic  last;
  } res_t;

  // does position idx come from parent a
  function automatic logic from_a_fn(input mode_t mode, input addr_t idx, input cnt_t lo,
                                     input cnt_t hi, input logic mask);
    cnt_t i;
    logic r;
    i = {1'b0, idx};
    unique case (mode)
      MODE_SEGMENT: r = (i >= lo) && (i < hi);
      MODE_HEAD:    r = (i < lo);
      MODE_TAIL:    r = (i >= lo);
      MODE_MASK:    r = mask;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/poc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module poc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/poc_front.sv
// front end: config registers, parent loading and job creation
`default_nettype none

module poc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // config write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [poc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [poc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words
  input  wire logic                         push,
  output logic                              full,
  input  wire poc_pkg::cnt_t                cut_low,
  input  wire poc_pkg::cnt_t                cut_high,
  input  wire logic                         last_gene,
  // hold-off while a child is being built
  input  wire logic                         hold,
  // parent store writes
  output logic                              st_we,
  output poc_pkg::addr_t                    st_addr,
  // job queue
  output logic                              job_push,
  output poc_pkg::job_t                     job
);

  poc_pkg::mode_t mode_r, mode_nxt;
  poc_pkg::cnt_t  len_r, len_nxt;
  poc_pkg::addr_t pos_r, pos_nxt;
  poc_pkg::cnt_t  n_eff;
  poc_pkg::cnt_t  pos_inc;
  poc_pkg::cnt_t  lo_c, hi_c;
  logic           accept;
  logic           final_word;

  assign cfg_ready = 1'b1;
  assign full      = hold;
  assign accept    = push && !hold;

  // config register writes
  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    if (cfg_valid) begin
      unique case (poc_pkg::cfg_reg_t'(cfg_index))
        poc_pkg::REG_MODE: mode_nxt = poc_pkg::mode_t'(cfg_data[1:0]);
        poc_pkg::REG_LEN:  len_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // effective length saturated to the supported range
  always_comb begin
    priority if (len_r < poc_pkg::LEN_MIN) begin
      n_eff = poc_pkg::LEN_MIN;
    end else if (len_r > poc_pkg::LEN_MAX) begin
      n_eff = poc_pkg::LEN_MAX;
    end else begin
      n_eff = len_r;
    end
  end

  // load position and end of parents
  assign pos_inc    = {1'b0, pos_r} + poc_pkg::cnt_t'(1);
  assign final_word = last_gene || !(pos_inc < n_eff);

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = final_word ? '0 : pos_inc[poc_pkg::ADDR_W-1:0];
    end
  end

  assign st_we   = accept;
  assign st_addr = pos_r;

  // cut points clamped, swapped for the segment mode
  assign lo_c = (cut_low > n_eff) ? n_eff : cut_low;
  assign hi_c = (cut_high > n_eff) ? n_eff : cut_high;

  always_comb begin
    job.len  = n_eff;
    job.mode = mode_r;
    job.lo   = lo_c;
    job.hi   = hi_c;
    if (mode_r == poc_pkg::MODE_SEGMENT && lo_c > hi_c) begin
      job.lo = hi_c;
      job.hi = lo_c;
    end
  end

  assign job_push = accept && final_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= poc_pkg::MODE_SEGMENT;
      len_r  <= poc_pkg::LEN_RESET;
      pos_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/poc_job_q.sv
// two-entry queue of child build jobs between front and back end
`default_nettype none

module poc_job_q (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire poc_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               not_empty,
  output poc_pkg::job_t      head
);

  poc_pkg::job_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign not_empty = (count_r != 2'd0);
  assign head      = q_r[rd_ptr_r];
  assign do_push   = push && (count_r != 2'd2);
  assign do_pop    = pop && not_empty;

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/poc_back.sv
// back end: marks genes taken from a, then emits the child through a small queue
`default_nettype none

module poc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  // job queue
  input  wire logic           job_valid,
  input  wire poc_pkg::job_t  job,
  output logic                job_pop,
  // parent store reads
  output poc_pkg::addr_t      a_rd_addr,
  input  wire poc_pkg::gene_t a_rd_data,
  input  wire logic           m_rd_data,
  output poc_pkg::addr_t      b_rd_addr,
  input  wire poc_pkg::gene_t b_rd_data,
  output logic                busy,
  // result words
  output logic                empty,
  input  wire logic           pop,
  output poc_pkg::gene_t      child_gene,
  output logic                last_child_gene
);

  poc_pkg::bk_state_t state_r, state_nxt;
  poc_pkg::job_t      job_r, job_nxt;
  poc_pkg::cnt_t      cnt_r, cnt_nxt;
  poc_pkg::cnt_t      j_r, j_nxt;
  logic               pend_r, pend_nxt;
  poc_pkg::addr_t     idx_d_r, idx_d_nxt;
  logic [poc_pkg::MAX_GENES-1:0] from_a_r, from_a_nxt;
  logic [poc_pkg::MAX_GENES-1:0] taken_r, taken_nxt;

  logic           issue;
  logic           fa_d;
  logic           cur_fa;
  logic           is_last;
  logic           b_done;
  logic           want_push;
  logic           skip_b;
  logic           res_push;
  poc_pkg::res_t  res;

  // output queue
  poc_pkg::res_t                 oq_r [poc_pkg::OQ_DEPTH];
  logic [poc_pkg::OQ_PTR_W-1:0]  oq_wr_r, oq_wr_nxt;
  logic [poc_pkg::OQ_PTR_W-1:0]  oq_rd_r, oq_rd_nxt;
  logic [poc_pkg::OQ_CNT_W-1:0]  oq_cnt_r, oq_cnt_nxt;
  logic                          oq_full;
  logic                          oq_pop;

  assign oq_full = (oq_cnt_r == poc_pkg::OQ_CNT_W'(poc_pkg::OQ_DEPTH));
  assign busy    = (state_r != poc_pkg::BK_IDLE);

  // store read addresses follow the position and b scan counters
  assign a_rd_addr = cnt_r[poc_pkg::ADDR_W-1:0];
  assign b_rd_addr = j_r[poc_pkg::ADDR_W-1:0];

  // decode of the current position
  assign issue   = (cnt_r < job_r.len);
  assign fa_d    = poc_pkg::from_a_fn(job_r.mode, idx_d_r, job_r.lo, job_r.hi, m_rd_data);
  assign cur_fa  = from_a_r[cnt_r[poc_pkg::ADDR_W-1:0]];
  assign is_last = (cnt_r == job_r.len - poc_pkg::cnt_t'(1));
  assign b_done  = !(j_r < job_r.len);

  // emit decision in the check state
  always_comb begin
    want_push = 1'b0;
    skip_b    = 1'b0;
    res.gene  = '0;
    res.last  = is_last;
    if (state_r == poc_pkg::BK_CHECK) begin
      priority if (cur_fa) begin
        want_push = 1'b1;
        res.gene  = a_rd_data;
      end else if (b_done) begin
        want_push = 1'b1;
      end else if (taken_r[b_rd_data]) begin
        skip_b = 1'b1;
      end else begin
        want_push = 1'b1;
        res.gene  = b_rd_data;
      end
    end
  end

  assign res_push = want_push && !oq_full;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      poc_pkg::BK_IDLE: begin
        if (job_valid) begin
          state_nxt = poc_pkg::BK_MARK;
        end
      end
      poc_pkg::BK_MARK: begin
        if (!issue && !pend_r) begin
          state_nxt = poc_pkg::BK_WAIT;
        end
      end
      poc_pkg::BK_WAIT: begin
        state_nxt = poc_pkg::BK_CHECK;
      end
      poc_pkg::BK_CHECK: begin
        priority if (res_push) begin
          state_nxt = is_last ? poc_pkg::BK_IDLE : poc_pkg::BK_WAIT;
        end else if (skip_b) begin
          state_nxt = poc_pkg::BK_WAIT;
        end
      end
      default: state_nxt = poc_pkg::BK_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    job_pop    = 1'b0;
    job_nxt    = job_r;
    cnt_nxt    = cnt_r;
    j_nxt      = j_r;
    pend_nxt   = 1'b0;
    idx_d_nxt  = idx_d_r;
    from_a_nxt = from_a_r;
    taken_nxt  = taken_r;
    unique case (state_r)
      poc_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          job_nxt    = job;
          cnt_nxt    = '0;
          j_nxt      = '0;
          from_a_nxt = '0;
          taken_nxt  = '0;
        end
      end
      poc_pkg::BK_MARK: begin
        // read a and mask at cnt, consume the word read in the cycle before
        pend_nxt  = issue;
        idx_d_nxt = cnt_r[poc_pkg::ADDR_W-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + poc_pkg::cnt_t'(1);
        end
        if (pend_r) begin
          from_a_nxt[idx_d_r] = fa_d;
          if (fa_d) begin
            taken_nxt[a_rd_data] = 1'b1;
          end
        end
        if (!issue && !pend_r) begin
          cnt_nxt = '0;
        end
      end
      poc_pkg::BK_WAIT: ;
      poc_pkg::BK_CHECK: begin
        if (skip_b) begin
          j_nxt = j_r + poc_pkg::cnt_t'(1);
        end
        if (res_push) begin
          cnt_nxt = cnt_r + poc_pkg::cnt_t'(1);
          if (!cur_fa && !b_done) begin
            j_nxt = j_r + poc_pkg::cnt_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= poc_pkg::BK_IDLE;
      pend_r  <= 1'b0;
      taken_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      taken_r <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    cnt_r    <= cnt_nxt;
    j_r      <= j_nxt;
    idx_d_r  <= idx_d_nxt;
    from_a_r <= from_a_nxt;
  end

  // output queue pointers
  assign oq_pop = pop && !empty;
  assign empty  = (oq_cnt_r == '0);

  always_comb begin
    oq_wr_nxt  = res_push ? oq_wr_r + poc_pkg::OQ_PTR_W'(1) : oq_wr_r;
    oq_rd_nxt  = oq_pop ? oq_rd_r + poc_pkg::OQ_PTR_W'(1) : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r + poc_pkg::OQ_CNT_W'(res_push) - poc_pkg::OQ_CNT_W'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  assign child_gene      = oq_r[oq_rd_r].gene;
  assign last_child_gene = oq_r[oq_rd_r].last;

endmodule

`default_nettype wire

FILE: rtl/core/permutation_order_crossover.sv
// top level of the permutation order crossover block
`default_nettype none

// Builds one child permutation from two parents by linear order crossover.
// One parent position is loaded per cycle while full is low; the word that
// carries last_gene, or the one at position sequence_length-1, closes the
// parents and hands a job to the back end. The back end then scans parent A
// and marks the genes it copies, and then emits each child gene, skipping
// genes of parent B that are already taken; its wait state covers the read
// latency of the parent memories. Loading of the next parents is held off
// (full is high) from the closing word until the back end has put the last
// child gene into its 4-word result queue. Configuration must be written
// through cfg_* while no child is in progress; the block itself does not
// enforce this.
module permutation_order_crossover (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [poc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [poc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [5:0]                     in_gene_a,
  input  wire logic [5:0]                     in_gene_b,
  input  wire logic                           in_take_from_a,
  input  wire logic [6:0]                     in_cut_low,
  input  wire logic [6:0]                     in_cut_high,
  input  wire logic                           in_last_gene,
  // result words
  output logic                                empty,
  input  wire logic                           pop,
  output logic [5:0]                          out_child_gene,
  output logic                                out_last_child_gene
);

  logic           st_we;
  poc_pkg::addr_t st_addr;
  logic           job_push;
  poc_pkg::job_t  job_in;
  logic           job_valid;
  poc_pkg::job_t  job_head;
  logic           job_pop;
  logic           back_busy;
  logic           hold;
  poc_pkg::addr_t a_rd_addr;
  poc_pkg::addr_t b_rd_addr;
  poc_pkg::gene_t a_rd_data;
  poc_pkg::gene_t b_rd_data;
  logic           m_rd_data;

  // no loading while a child is queued or being built
  assign hold = job_valid || back_busy;

  // front end
  poc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .cut_low     (in_cut_low),
    .cut_high    (in_cut_high),
    .last_gene   (in_last_gene),
    .hold        (hold),
    .st_we       (st_we),
    .st_addr     (st_addr),
    .job_push    (job_push),
    .job         (job_in)
  );

  // parent stores
  poc_ram #(.WIDTH(poc_pkg::GENE_W), .DEPTH(poc_pkg::MAX_GENES)) u_store_a (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_addr),
    .wr_data (in_gene_a),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  poc_ram #(.WIDTH(poc_pkg::GENE_W), .DEPTH(poc_pkg::MAX_GENES)) u_store_b (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_addr),
    .wr_data (in_gene_b),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  poc_ram #(.WIDTH(1), .DEPTH(poc_pkg::MAX_GENES)) u_store_mask (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_addr),
    .wr_data (in_take_from_a),
    .rd_addr (a_rd_addr),
    .rd_data (m_rd_data)
  );

  // job queue
  poc_job_q u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (job_in),
    .pop       (job_pop),
    .not_empty (job_valid),
    .head      (job_head)
  );

  // back end
  poc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job             (job_head),
    .job_pop         (job_pop),
    .a_rd_addr       (a_rd_addr),
    .a_rd_data       (a_rd_data),
    .m_rd_data       (m_rd_data),
    .b_rd_addr       (b_rd_addr),
    .b_rd_data       (b_rd_data),
    .busy            (back_busy),
    .empty           (empty),
    .pop             (pop),
    .child_gene      (out_child_gene),
    .last_child_gene (out_last_child_gene)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_permutation_order_crossover.sv
// self-checking testbench for the permutation order crossover block
`default_nettype none

module tb_permutation_order_crossover;
  import poc_pkg::*;

  localparam int CYCLE_LIMIT  = 6000000;
  localparam int RANDOM_WORDS = 320;
  localparam int SETTLE_CYCLES = 20;

  // kinds of generated children
  typedef enum int {
    CHILD_PERM,
    CHILD_NOISE,
    CHILD_SHORT
  } child_kind_t;

  // one parent load word
  typedef struct {
    logic [5:0] gene_a;
    logic [5:0] gene_b;
    logic       take;
    logic [6:0] cut_lo;
    logic [6:0] cut_hi;
    logic       last;
  } parent_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic       push = 1'b0;
  logic       full;
  logic [5:0] in_gene_a = '0;
  logic [5:0] in_gene_b = '0;
  logic       in_take_from_a = 1'b0;
  logic [6:0] in_cut_low = '0;
  logic [6:0] in_cut_high = '0;
  logic       in_last_gene = 1'b0;

  logic       empty;
  logic       pop = 1'b0;
  logic [5:0] out_child_gene;
  logic       out_last_child_gene;

  permutation_order_crossover DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .push                (push),
    .full                (full),
    .in_gene_a           (in_gene_a),
    .in_gene_b           (in_gene_b),
    .in_take_from_a      (in_take_from_a),
    .in_cut_low          (in_cut_low),
    .in_cut_high         (in_cut_high),
    .in_last_gene        (in_last_gene),
    .empty               (empty),
    .pop                 (pop),
    .out_child_gene      (out_child_gene),
    .out_last_child_gene (out_last_child_gene)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block state
  gene_t      a_mem [MAX_GENES];
  gene_t      b_mem [MAX_GENES];
  logic       mask_mem [MAX_GENES];
  int         load_pos = 0;
  mode_t      mode_reg = MODE_SEGMENT;
  logic [6:0] len_reg = 7'd32;

  res_t         expected_genes [$];
  parent_word_t pending_words [$];
  parent_word_t cur_word;
  int           words_queued = 0;
  int           words_accepted = 0;
  int           written_cnt = 0;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           push_wait = 0;
  int           pop_wait = 0;
  bit           no_idle = 1'b0;
  res_t         exp_w;

  // child length after saturation
  function automatic int child_len();
    int n;
    n = int'(len_reg);
    if (n < 2) n = 2;
    if (n > MAX_GENES) n = MAX_GENES;
    return n;
  endfunction

  // random gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // store one parent word, build the child when the parents close
  task automatic crossover_load(input parent_word_t w);
    int n, lo, hi, t, j;
    logic [63:0] taken;
    logic        sel [MAX_GENES];
    res_t        r;
    n = child_len();
    a_mem[load_pos] = w.gene_a;
    b_mem[load_pos] = w.gene_b;
    mask_mem[load_pos] = w.take;
    if (!w.last && load_pos + 1 < n) begin
      load_pos++;
      return;
    end
    lo = (int'(w.cut_lo) > n) ? n : int'(w.cut_lo);
    hi = (int'(w.cut_hi) > n) ? n : int'(w.cut_hi);
    if (mode_reg == MODE_SEGMENT && lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    taken = '0;
    for (int i = 0; i < n; i++) begin
      case (mode_reg)
        MODE_SEGMENT: sel[i] = (i >= lo) && (i < hi);
        MODE_HEAD:    sel[i] = (i < lo);
        MODE_TAIL:    sel[i] = (i >= lo);
        default:      sel[i] = mask_mem[i];
      endcase
      if (sel[i]) taken[a_mem[i]] = 1'b1;
    end
    // fill the rest from parent b in order, skipping genes copied from a
    j = 0;
    for (int i = 0; i < n; i++) begin
      if (sel[i]) begin
        r.gene = a_mem[i];
      end else begin
        while (j < n && taken[b_mem[j]]) j++;
        if (j < n) begin
          r.gene = b_mem[j];
          j++;
        end else begin
          r.gene = '0;
        end
      end
      r.last = (i == n - 1);
      expected_genes.push_back(r);
    end
    load_pos = 0;
  endtask

  task automatic add_word(input logic [5:0] ga, input logic [5:0] gb, input logic take,
                          input logic [6:0] lo, input logic [6:0] hi, input logic last);
    parent_word_t w;
    w.gene_a = ga;
    w.gene_b = gb;
    w.take = take;
    w.cut_lo = lo;
    w.cut_hi = hi;
    w.last = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // cut point biased toward the edges and beyond the length
  function automatic logic [6:0] pick_cut(input int n);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'(n);
    if (r == 2) return 7'($urandom_range(n, MAX_GENES));
    return 7'($urandom_range(0, n));
  endfunction

  // queue the parent words of one child
  task automatic queue_child(input child_kind_t kind);
    int n, k, t, idx;
    int pool [MAX_GENES];
    int bperm [MAX_GENES];
    logic [5:0] ga, gb;
    logic last;
    n = child_len();
    k = n;
    if (kind == CHILD_SHORT && written_cnt >= n) k = $urandom_range(1, n - 1);
    for (int i = 0; i < MAX_GENES; i++) pool[i] = i;
    for (int i = MAX_GENES - 1; i > 0; i--) begin
      idx = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[idx];
      pool[idx] = t;
    end
    // parent b is a reordering of the genes of parent a
    for (int i = 0; i < n; i++) bperm[i] = pool[i];
    for (int i = n - 1; i > 0; i--) begin
      idx = $urandom_range(0, i);
      t = bperm[i];
      bperm[i] = bperm[idx];
      bperm[idx] = t;
    end
    for (int p = 0; p < k; p++) begin
      ga = 6'(pool[p]);
      gb = 6'(bperm[p]);
      if (kind == CHILD_NOISE) begin
        ga = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 1)) gb = 6'($urandom_range(0, 63));
      end
      if (p != k - 1) last = 1'b0;
      else if (k < n) last = 1'b1;
      else last = 1'($urandom_range(0, 1));
      add_word(ga, gb, 1'($urandom_range(0, 1)), pick_cut(n), pick_cut(n), last);
    end
    if (k > written_cnt) written_cnt = k;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MODE) mode_reg = mode_t'(val[1:0]);
    else len_reg = val;
  endtask

  task automatic set_config(input mode_t mode, input logic [6:0] len);
    write_reg(REG_MODE, 7'(mode));
    write_reg(REG_LEN, len);
  endtask

  // hold off until every queued word is in and every child word is out
  task automatic drain();
    while (words_accepted != words_queued || expected_genes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver: one parent word per push handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      push_wait = 0;
    end else begin
      if (push && !full) begin
        crossover_load(cur_word);
        words_accepted++;
      end
      if (!push || !full) begin
        if (push_wait > 0 || pending_words.size() == 0) begin
          if (push_wait > 0) push_wait--;
          push <= 1'b0;
        end else begin
          cur_word = pending_words.pop_front();
          in_gene_a <= cur_word.gene_a;
          in_gene_b <= cur_word.gene_b;
          in_take_from_a <= cur_word.take;
          in_cut_low <= cur_word.cut_lo;
          in_cut_high <= cur_word.cut_hi;
          in_last_gene <= cur_word.last;
          push <= 1'b1;
          push_wait = pick_gap();
        end
      end
    end
  end

  // monitor: check each popped child word against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      pop_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_genes.size() == 0) begin
          $error("unexpected child word: child_gene %0d last_child_gene %0b",
                 out_child_gene, out_last_child_gene);
          fail_count++;
        end else begin
          exp_w = expected_genes.pop_front();
          if (out_child_gene !== exp_w.gene) begin
            $error("child_gene: expected %0d, actual %0d", exp_w.gene, out_child_gene);
            fail_count++;
          end
          if (out_last_child_gene !== exp_w.last) begin
            $error("last_child_gene: expected %0b, actual %0b", exp_w.last,
                   out_last_child_gene);
            fail_count++;
          end
        end
        pop_wait = pick_gap();
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    int r, start_words, children;
    logic [6:0] len;
    child_kind_t kind;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // one child on the reset register values
    queue_child(CHILD_PERM);
    drain();

    // both cuts swapped, whole child from a, gene extremes
    set_config(MODE_SEGMENT, 7'd2);
    add_word(6'd0, 6'd63, 1'b1, 7'd2, 7'd0, 1'b0);
    add_word(6'd63, 6'd0, 1'b0, 7'd2, 7'd0, 1'b1);
    // cuts beyond the length, empty segment
    add_word(6'd63, 6'd0, 1'b0, 7'd64, 7'd64, 1'b0);
    add_word(6'd0, 6'd63, 1'b1, 7'd64, 7'd64, 1'b0);
    // parent b exhausted: second position gets zero
    add_word(6'd5, 6'd5, 1'b0, 7'd0, 7'd1, 1'b0);
    add_word(6'd9, 6'd5, 1'b0, 7'd0, 7'd1, 1'b1);
    drain();

    set_config(MODE_HEAD, 7'd2);
    add_word(6'd10, 6'd20, 1'b0, 7'd0, 7'd0, 1'b0);
    add_word(6'd20, 6'd10, 1'b0, 7'd1, 7'd0, 1'b0);
    drain();

    set_config(MODE_TAIL, 7'd2);
    add_word(6'd1, 6'd2, 1'b0, 7'd0, 7'd0, 1'b0);
    add_word(6'd2, 6'd1, 1'b0, 7'd0, 7'd0, 1'b0);
    add_word(6'd1, 6'd2, 1'b1, 7'd0, 7'd0, 1'b0);
    add_word(6'd2, 6'd1, 1'b1, 7'd64, 7'd0, 1'b0);
    drain();

    set_config(MODE_MASK, 7'd2);
    add_word(6'd5, 6'd6, 1'b1, 7'd0, 7'd0, 1'b0);
    add_word(6'd6, 6'd5, 1'b0, 7'd0, 7'd0, 1'b0);
    add_word(6'd5, 6'd6, 1'b0, 7'd0, 7'd0, 1'b0);
    add_word(6'd6, 6'd5, 1'b1, 7'd0, 7'd0, 1'b1);
    drain();

    // duplicate gene in parent b used twice, then a short packet
    set_config(MODE_HEAD, 7'd3);
    add_word(6'd1, 6'd7, 1'b0, 7'd0, 7'd0, 1'b0);
    add_word(6'd7, 6'd7, 1'b0, 7'd0, 7'd0, 1'b0);
    add_word(6'd9, 6'd1, 1'b0, 7'd0, 7'd0, 1'b0);
    add_word(6'd3, 6'd9, 1'b0, 7'd2, 7'd0, 1'b1);
    drain();

    // length below the minimum saturates to two
    set_config(MODE_SEGMENT, 7'd1);
    add_word(6'd4, 6'd8, 1'b0, 7'd1, 7'd2, 1'b0);
    add_word(6'd8, 6'd4, 1'b0, 7'd1, 7'd2, 1'b0);
    drain();

    // random phases: mostly valid permutations, some noise and short packets
    start_words = words_queued;
    for (int phase = 0; words_queued - start_words < RANDOM_WORDS; phase++) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (phase == 2) len = 7'd64;
      else if (phase == 5) len = 7'd0;
      else if (phase == 8) len = 7'd127;
      else if (r < 65) len = 7'($urandom_range(2, 12));
      else if (r < 85) len = 7'($urandom_range(13, 32));
      else if (r < 95) len = 7'($urandom_range(33, 64));
      else if (r < 97) len = 7'($urandom_range(0, 1));
      else len = 7'($urandom_range(65, 127));
      set_config(mode_t'($urandom_range(0, 3)), len);
      children = (child_len() > 32) ? 1 : $urandom_range(1, 4);
      repeat (children) begin
        r = $urandom_range(0, 99);
        if (r < 75) kind = CHILD_PERM;
        else if (r < 88) kind = CHILD_NOISE;
        else kind = CHILD_SHORT;
        queue_child(kind);
      end
      drain();
    end

    if (fail_count == 0 && expected_genes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/poc_pkg.sv
rtl/core/poc_ram.sv
rtl/core/poc_front.sv
rtl/core/poc_job_q.sv
rtl/core/poc_back.sv
rtl/core/permutation_order_crossover.sv
tb/sv/tb_permutation_order_crossover.sv
